// ----- sv/dreq_pkg.sv -----
// shared types and constants for the disk request elevator queue
package dreq_pkg;

  // default sizes of the request pool and the number of disk units
  localparam int DREQ_DEPTH = 64;
  localparam int DREQ_UNITS = 2;

  // sectors on one track; a start sector at or above this is rejected
  localparam int SECTORS_PER_TRACK = 16;

  // number of pool entries checked per cycle by the free-entry search
  localparam int ScanGroup = 8;

  // reset value of the per-unit track count registers
  localparam logic [10:0] TRACKS_RESET = 11'd1024;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // configuration register indexes
  localparam logic CFG_TRACKS_UNIT0 = 1'b0;
  localparam logic CFG_TRACKS_UNIT1 = 1'b1;

  // result status codes
  localparam logic [2:0] ST_INSERTED   = 3'd0;
  localparam logic [2:0] ST_BAD_TRACK  = 3'd1;
  localparam logic [2:0] ST_BAD_SECTOR = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_POPPED     = 3'd4;
  localparam logic [2:0] ST_EMPTY      = 3'd5;

  // one stored request, 29 bits
  typedef struct packed {
    logic [9:0] track;
    logic [3:0] sector;
    logic [7:0] count;
    logic       is_write;
    logic [5:0] requester;
  } req_t;

endpackage

// ----- sv/dreq_free_scan.sv -----
// lowest free pool entry within one group of the entry-used bits
module dreq_free_scan import dreq_pkg::*; #(
  parameter int DEPTH = DREQ_DEPTH,
  localparam int IdxW = $clog2(DEPTH),
  localparam int NGrp = (DEPTH + ScanGroup - 1) / ScanGroup,
  localparam int GrpW = (NGrp > 1) ? $clog2(NGrp) : 1
) (
  input  logic [DEPTH-1:0] used_i,
  input  logic [GrpW-1:0]  grp_i,
  output logic             hit_o,
  output logic [IdxW-1:0]  slot_o
);

  logic [NGrp*ScanGroup-1:0] used_pad;
  logic [ScanGroup-1:0]      grp_bits;
  logic [2:0]                pos;

  // entries past the pool count as used
  always_comb begin
    used_pad = '1;
    used_pad[DEPTH-1:0] = used_i;
  end

  assign grp_bits = used_pad[grp_i*ScanGroup +: ScanGroup];

  // priority pick of the lowest clear bit
  always_comb begin
    pos = '0;
    for (int i = ScanGroup - 1; i >= 0; i--) begin
      if (!grp_bits[i]) begin
        pos = 3'(i);
      end
    end
  end

  assign hit_o  = ~&grp_bits;
  assign slot_o = IdxW'({grp_i, pos});

endmodule

// ----- sv/disk_request_elevator_queue_top.sv -----
// circular-scan disk request queue: pooled linked lists in two memories
//
// Usage: an operation word is taken at a clock edge with start high and busy
// low. op selects insert (link a request into the addressed unit's list in
// elevator order) or pop (return and remove the head request). Every
// operation gives exactly one result word on done_o for one cycle, with the
// status and, for a pop, the request fields; other statuses show zero fields.
// A rejected insert or an empty pop answers in the cycle after accept; a pop
// reads the head entry at accept and answers from the S_POP state. An insert
// searches the used bits eight entries a cycle and ends there for an empty
// list or a full pool; else it reads the head in S_WHEAD, walks the list one
// linked entry per cycle (past at most DEPTH-2 entries) through the memory
// read port, then writes the links in S_LINK and S_LINK2; the walk is the
// longest step. One operation is in work at a time; busy stays high until
// its result is out. Reset empties all lists and sets both track counts to
// 1024; the memories need no clearing. The receiver cannot stall, so results
// are never held. Track counts are written through the cfg port only while
// the block is idle: a rule for the user, which the block does not enforce.
module disk_request_elevator_queue_top import dreq_pkg::*; #(
  parameter int DEPTH = DREQ_DEPTH,
  parameter int UNITS = DREQ_UNITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        op_i,
  input  logic        disk_unit_i,
  input  logic [9:0]  req_track_i,
  input  logic [3:0]  req_sector_i,
  input  logic [7:0]  sector_count_i,
  input  logic        is_write_i,
  input  logic [5:0]  requester_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [10:0] cfg_wdata_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [9:0]  out_track_o,
  output logic [3:0]  out_sector_o,
  output logic [7:0]  out_count_o,
  output logic        out_is_write_o,
  output logic [5:0]  out_requester_o
);

  localparam int IdxW  = $clog2(DEPTH);
  localparam int LenW  = $clog2(DEPTH + 1);
  localparam int NGrp  = (DEPTH + ScanGroup - 1) / ScanGroup;
  localparam int GrpW  = (NGrp > 1) ? $clog2(NGrp) : 1;
  localparam int UnitW = (UNITS > 1) ? $clog2(UNITS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_WHEAD = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_LINK  = 3'd5;
  localparam logic [2:0] S_LINK2 = 3'd6;

  // control state
  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] head_q [UNITS];
  logic [IdxW-1:0] head_d [UNITS];
  logic [LenW-1:0] len_q [UNITS];
  logic [LenW-1:0] len_d [UNITS];
  logic [DEPTH-1:0] used_q, used_d;
  logic [10:0]     tracks0_q, tracks0_d, tracks1_q, tracks1_d;
  logic            done_q, done_d;

  // operation in work
  logic [UnitW-1:0] unit_q, unit_d;
  req_t             req_q, req_d;
  logic [IdxW-1:0]  slot_q, slot_d;
  logic [GrpW-1:0]  grp_q, grp_d;
  logic [IdxW-1:0]  a_q, a_d;
  logic [9:0]       trk_a_q, trk_a_d;
  logic [IdxW-1:0]  nxt_a_q, nxt_a_d;
  logic [LenW-1:0]  pos_q, pos_d;
  logic             fwd_q, fwd_d, ph2_q, ph2_d, has_next_q, has_next_d;

  // result word
  logic [2:0] status_q, status_d;
  req_t       out_q, out_d;

  // memories and their ports
  req_t            ent_mem [DEPTH];
  logic [IdxW-1:0] lnk_mem [DEPTH];
  logic [IdxW-1:0] rd_addr;
  req_t            rd_ent_q;
  logic [IdxW-1:0] rd_lnk_q;
  logic            ent_we, lnk_we;
  logic [IdxW-1:0] ent_waddr, lnk_waddr, lnk_wdata;

  // decode of the incoming word
  logic             unit_ok;
  logic [UnitW-1:0] unit_in;
  logic [10:0]      trk_limit;
  logic             bad_track, bad_sector;

  // free-entry search
  logic            scan_hit;
  logic [IdxW-1:0] scan_slot;

  // walk step
  logic [LenW:0] len_ext, pos_p2;
  logic [9:0]    trk_b;
  logic          c_fwd, c_asc, c_tail, cont;

  assign unit_ok    = 32'(disk_unit_i) < UNITS;
  assign unit_in    = unit_ok ? UnitW'(disk_unit_i) : '0;
  assign trk_limit  = disk_unit_i ? tracks1_q : tracks0_q;
  assign bad_track  = !unit_ok || ({1'b0, req_track_i} >= trk_limit);
  assign bad_sector = 32'(req_sector_i) >= SECTORS_PER_TRACK;

  assign len_ext = (LenW+1)'(len_q[unit_q]);
  assign pos_p2  = (LenW+1)'(pos_q) + (LenW+1)'(2);
  assign trk_b   = rd_ent_q.track;
  assign c_fwd   = (trk_b < req_q.track) && (trk_b > trk_a_q);
  assign c_asc   = trk_a_q <= trk_b;
  assign c_tail  = trk_b <= req_q.track;
  assign cont    = fwd_q ? c_fwd : (ph2_q ? c_tail : (c_asc || c_tail));

  assign busy = state_q != S_IDLE;

  dreq_free_scan #(
    .DEPTH (DEPTH)
  ) u_free_scan (
    .used_i (used_q),
    .grp_i  (grp_q),
    .hit_o  (scan_hit),
    .slot_o (scan_slot)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    len_d      = len_q;
    used_d     = used_q;
    tracks0_d  = tracks0_q;
    tracks1_d  = tracks1_q;
    unit_d     = unit_q;
    req_d      = req_q;
    slot_d     = slot_q;
    grp_d      = grp_q;
    a_d        = a_q;
    trk_a_d    = trk_a_q;
    nxt_a_d    = nxt_a_q;
    pos_d      = pos_q;
    fwd_d      = fwd_q;
    ph2_d      = ph2_q;
    has_next_d = has_next_q;
    done_d     = 1'b0;
    status_d   = status_q;
    out_d      = out_q;
    rd_addr    = head_q[unit_in];
    ent_we     = 1'b0;
    ent_waddr  = slot_q;
    lnk_we     = 1'b0;
    lnk_waddr  = slot_q;
    lnk_wdata  = '0;

    // configuration writes
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TRACKS_UNIT0: tracks0_d = cfg_wdata_i;
        CFG_TRACKS_UNIT1: tracks1_d = cfg_wdata_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          unit_d = unit_in;
          req_d  = '{track: req_track_i, sector: req_sector_i, count: sector_count_i,
                     is_write: is_write_i, requester: requester_i};
          grp_d  = '0;
          out_d  = '0;
          if (op_i == OP_POP) begin
            if (!unit_ok || len_q[unit_in] == '0) begin
              done_d   = 1'b1;
              status_d = ST_EMPTY;
            end else begin
              state_d = S_POP;
            end
          end else if (bad_track) begin
            done_d   = 1'b1;
            status_d = ST_BAD_TRACK;
          end else if (bad_sector) begin
            done_d   = 1'b1;
            status_d = ST_BAD_SECTOR;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      // look for the lowest free entry, one group a cycle
      S_SCAN: begin
        rd_addr = head_q[unit_q];
        if (scan_hit) begin
          slot_d = scan_slot;
          if (len_q[unit_q] == '0) begin
            ent_we           = 1'b1;
            ent_waddr        = scan_slot;
            head_d[unit_q]   = scan_slot;
            used_d[scan_slot] = 1'b1;
            len_d[unit_q]    = LenW'(1);
            done_d           = 1'b1;
            status_d         = ST_INSERTED;
            state_d          = S_IDLE;
          end else begin
            state_d = S_WHEAD;
          end
        end else if (grp_q == GrpW'(NGrp - 1)) begin
          done_d   = 1'b1;
          status_d = ST_FULL;
          state_d  = S_IDLE;
        end else begin
          grp_d = grp_q + GrpW'(1);
        end
      end

      // head entry and its link are on the read port
      S_POP: begin
        done_d                = 1'b1;
        status_d              = ST_POPPED;
        out_d                 = rd_ent_q;
        used_d[head_q[unit_q]] = 1'b0;
        len_d[unit_q]         = len_q[unit_q] - LenW'(1);
        head_d[unit_q]        = (len_q[unit_q] > LenW'(1)) ? rd_lnk_q : '0;
        state_d               = S_IDLE;
      end

      // head is the first walk position; fetch its successor
      S_WHEAD: begin
        rd_addr = rd_lnk_q;
        a_d     = head_q[unit_q];
        trk_a_d = rd_ent_q.track;
        nxt_a_d = rd_lnk_q;
        pos_d   = '0;
        fwd_d   = req_q.track > rd_ent_q.track;
        ph2_d   = 1'b0;
        if (len_ext > (LenW+1)'(1)) begin
          state_d = S_WALK;
        end else begin
          has_next_d = 1'b0;
          state_d    = S_LINK;
        end
      end

      // successor is on the read port; step or stop
      S_WALK: begin
        rd_addr = rd_lnk_q;
        if (cont) begin
          a_d     = nxt_a_q;
          trk_a_d = trk_b;
          nxt_a_d = rd_lnk_q;
          pos_d   = pos_q + LenW'(1);
          ph2_d   = ph2_q || (!fwd_q && !c_asc);
          if (pos_p2 < len_ext) begin
            state_d = S_WALK;
          end else begin
            has_next_d = 1'b0;
            state_d    = S_LINK;
          end
        end else begin
          has_next_d = 1'b1;
          state_d    = S_LINK;
        end
      end

      // write the new entry and its link
      S_LINK: begin
        ent_we    = 1'b1;
        lnk_we    = 1'b1;
        lnk_waddr = slot_q;
        lnk_wdata = has_next_q ? nxt_a_q : '0;
        state_d   = S_LINK2;
      end

      // hook the new entry behind the stop position
      S_LINK2: begin
        lnk_we         = 1'b1;
        lnk_waddr      = a_q;
        lnk_wdata      = slot_q;
        used_d[slot_q] = 1'b1;
        len_d[unit_q]  = len_q[unit_q] + LenW'(1);
        done_d         = 1'b1;
        status_d       = ST_INSERTED;
        state_d        = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // request and link memories
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= req_q;
    end
    if (lnk_we) begin
      lnk_mem[lnk_waddr] <= lnk_wdata;
    end
    rd_ent_q <= ent_mem[rd_addr];
    rd_lnk_q <= lnk_mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= '0;
      tracks0_q <= TRACKS_RESET;
      tracks1_q <= TRACKS_RESET;
      done_q    <= 1'b0;
      for (int u = 0; u < UNITS; u++) begin
        head_q[u] <= '0;
        len_q[u]  <= '0;
      end
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      tracks0_q <= tracks0_d;
      tracks1_q <= tracks1_d;
      done_q    <= done_d;
      head_q    <= head_d;
      len_q     <= len_d;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    unit_q     <= unit_d;
    req_q      <= req_d;
    slot_q     <= slot_d;
    grp_q      <= grp_d;
    a_q        <= a_d;
    trk_a_q    <= trk_a_d;
    nxt_a_q    <= nxt_a_d;
    pos_q      <= pos_d;
    fwd_q      <= fwd_d;
    ph2_q      <= ph2_d;
    has_next_q <= has_next_d;
    status_q   <= status_d;
    out_q      <= out_d;
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign out_track_o     = out_q.track;
  assign out_sector_o    = out_q.sector;
  assign out_count_o     = out_q.count;
  assign out_is_write_o  = out_q.is_write;
  assign out_requester_o = out_q.requester;

endmodule

// ----- test/disk_request_elevator_queue_top_tb.sv -----
// self-checking testbench for the elevator disk request queue: directed table, random phases
module disk_request_elevator_queue_top_tb import dreq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod   = 8;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 100;
  localparam int PhaseCount  = 10;
  localparam int PhaseWords  = 125;
  localparam int QuietPhases = 2;
  localparam int MaxPrinted  = 40;

  // one result word as the block reports it
  typedef struct packed {
    logic [2:0] status;
    logic [9:0] track;
    logic [3:0] sector;
    logic [7:0] count;
    logic       is_write;
    logic [5:0] requester;
  } result_t;

  // directed plan: a track count write or one operation word
  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic        op;
    logic        unit;
    req_t        rq;
    logic [10:0] cfg_val;
    logic        typed;
    result_t     want;
  } plan_row_t;

  localparam req_t    NoReq       = '0;
  localparam result_t NoRes       = '0;
  localparam result_t EmptyRes    = '{ST_EMPTY, 10'd0, 4'd0, 8'd0, 1'b0, 6'd0};
  localparam result_t InsertedRes = '{ST_INSERTED, 10'd0, 4'd0, 8'd0, 1'b0, 6'd0};
  localparam result_t BadTrackRes = '{ST_BAD_TRACK, 10'd0, 4'd0, 8'd0, 1'b0, 6'd0};

  localparam int PlanRows = 31;
  localparam plan_row_t DirectedPlan [PlanRows] = '{
    // both track counts written right after reset
    '{ROW_CFG, OP_INSERT, CFG_TRACKS_UNIT0, NoReq, 11'd1024, 1'b0, NoRes},
    '{ROW_CFG, OP_INSERT, CFG_TRACKS_UNIT1, NoReq, 11'd1024, 1'b0, NoRes},
    // pops of empty lists, then field extremes through insert and pop
    '{ROW_WORD, OP_POP, 1'b0, NoReq, 11'd0, 1'b1, EmptyRes},
    '{ROW_WORD, OP_POP, 1'b1, NoReq, 11'd0, 1'b1, EmptyRes},
    '{ROW_WORD, OP_INSERT, 1'b0, '{10'd1023, 4'd15, 8'd255, 1'b1, 6'd63}, 11'd0,
      1'b1, InsertedRes},
    '{ROW_WORD, OP_POP, 1'b0, NoReq, 11'd0, 1'b1,
      '{ST_POPPED, 10'd1023, 4'd15, 8'd255, 1'b1, 6'd63}},
    '{ROW_WORD, OP_INSERT, 1'b1, NoReq, 11'd0, 1'b1, InsertedRes},
    '{ROW_WORD, OP_POP, 1'b1, NoReq, 11'd0, 1'b1,
      '{ST_POPPED, 10'd0, 4'd0, 8'd0, 1'b0, 6'd0}},
    '{ROW_WORD, OP_POP, 1'b1, NoReq, 11'd0, 1'b1, EmptyRes},
    // forward walk, wrap past the ascending run, equal tracks, shared pool
    '{ROW_WORD, OP_INSERT, 1'b0, '{10'd500, 4'd1, 8'd10, 1'b0, 6'd1}, 11'd0, 1'b0, NoRes},
    '{ROW_WORD, OP_INSERT, 1'b0, '{10'd700, 4'd2, 8'd20, 1'b1, 6'd2}, 11'd0, 1'b0, NoRes},
    '{ROW_WORD, OP_INSERT, 1'b0, '{10'd600, 4'd3, 8'd30, 1'b0, 6'd3}, 11'd0, 1'b0, NoRes},
    '{ROW_WORD, OP_INSERT, 1'b1, '{10'd300, 4'd4, 8'd40, 1'b1, 6'd4}, 11'd0, 1'b0, NoRes},
    '{ROW_WORD, OP_INSERT, 1'b0, '{10'd900, 4'd5, 8'd50, 1'b0, 6'd5}, 11'd0, 1'b0, NoRes},
    '{ROW_WORD, OP_INSERT, 1'b0, '{10'd100, 4'd6, 8'd60, 1'b1, 6'd6}, 11'd0, 1'b0, NoRes},
    '{ROW_WORD, OP_INSERT, 1'b0, '{10'd50, 4'd7, 8'd70, 1'b0, 6'd7}, 11'd0, 1'b0, NoRes},
    '{ROW_WORD, OP_INSERT, 1'b0, '{10'd100, 4'd8, 8'd80, 1'b1, 6'd8}, 11'd0, 1'b0, NoRes},
    '{ROW_WORD, OP_INSERT, 1'b0, '{10'd500, 4'd9, 8'd90, 1'b0, 6'd9}, 11'd0, 1'b0, NoRes},
    '{ROW_WORD, OP_INSERT, 1'b0, '{10'd950, 4'd10, 8'd100, 1'b1, 6'd10}, 11'd0, 1'b0,
      NoRes},
    '{ROW_WORD, OP_POP, 1'b0, NoReq, 11'd0, 1'b0, NoRes},
    '{ROW_WORD, OP_POP, 1'b0, NoReq, 11'd0, 1'b0, NoRes},
    '{ROW_WORD, OP_POP, 1'b1, NoReq, 11'd0, 1'b0, NoRes},
    // track limit edges: one track, zero tracks, largest register value
    '{ROW_CFG, OP_INSERT, CFG_TRACKS_UNIT0, NoReq, 11'd1, 1'b0, NoRes},
    '{ROW_WORD, OP_INSERT, 1'b0, '{10'd1, 4'd2, 8'd3, 1'b0, 6'd4}, 11'd0, 1'b1,
      BadTrackRes},
    '{ROW_WORD, OP_INSERT, 1'b0, '{10'd0, 4'd2, 8'd3, 1'b0, 6'd4}, 11'd0, 1'b1,
      InsertedRes},
    '{ROW_CFG, OP_INSERT, CFG_TRACKS_UNIT0, NoReq, 11'd0, 1'b0, NoRes},
    '{ROW_WORD, OP_INSERT, 1'b0, '{10'd0, 4'd5, 8'd6, 1'b1, 6'd7}, 11'd0, 1'b1,
      BadTrackRes},
    '{ROW_CFG, OP_INSERT, CFG_TRACKS_UNIT1, NoReq, 11'd2047, 1'b0, NoRes},
    '{ROW_WORD, OP_INSERT, 1'b1, '{10'd1023, 4'd0, 8'd1, 1'b1, 6'd0}, 11'd0, 1'b1,
      InsertedRes},
    '{ROW_CFG, OP_INSERT, CFG_TRACKS_UNIT0, NoReq, 11'd1024, 1'b0, NoRes},
    '{ROW_CFG, OP_INSERT, CFG_TRACKS_UNIT1, NoReq, 11'd1024, 1'b0, NoRes}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        op_i = OP_INSERT;
  logic        disk_unit_i = 1'b0;
  logic [9:0]  req_track_i = '0;
  logic [3:0]  req_sector_i = '0;
  logic [7:0]  sector_count_i = '0;
  logic        is_write_i = 1'b0;
  logic [5:0]  requester_i = '0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = CFG_TRACKS_UNIT0;
  logic [10:0] cfg_wdata_i = '0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [9:0]  out_track_o;
  logic [3:0]  out_sector_o;
  logic [7:0]  out_count_o;
  logic        out_is_write_o;
  logic [5:0]  out_requester_o;

  // mirror of the request pool, the per-unit lists and the track counts
  req_t        pool_entry [DREQ_DEPTH];
  logic [5:0]  pool_next [DREQ_DEPTH];
  bit          pool_used [DREQ_DEPTH];
  logic [5:0]  list_head [DREQ_UNITS] = '{default: '0};
  int          list_len [DREQ_UNITS] = '{default: 0};
  logic [10:0] unit_tracks [DREQ_UNITS] = '{default: TRACKS_RESET};

  result_t awaited_words [$];
  result_t seen_want;
  int      mismatch_count = 0;
  int      quiet_cycles = 0;

  disk_request_elevator_queue_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .disk_unit_i    (disk_unit_i),
    .req_track_i    (req_track_i),
    .req_sector_i   (req_sector_i),
    .sector_count_i (sector_count_i),
    .is_write_i     (is_write_i),
    .requester_i    (requester_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .out_track_o    (out_track_o),
    .out_sector_o   (out_sector_o),
    .out_count_o    (out_count_o),
    .out_is_write_o (out_is_write_o),
    .out_requester_o(out_requester_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // applies one operation to the mirror and returns the word it should answer
  function automatic result_t queue_outcome(logic op, logic unit, req_t rq);
    result_t    res;
    int         slot;
    int         len;
    int         pos;
    int         i;
    logic [5:0] cur;
    logic [5:0] nxt;
    res = '0;
    len = list_len[unit];
    if (op == OP_INSERT) begin
      // lowest free pool entry
      slot = -1;
      for (i = DREQ_DEPTH - 1; i >= 0; i--) begin
        if (!pool_used[i]) slot = i;
      end
      if ({1'b0, rq.track} >= unit_tracks[unit]) begin
        res.status = ST_BAD_TRACK;
      end else if (rq.sector >= SECTORS_PER_TRACK) begin
        res.status = ST_BAD_SECTOR;
      end else if (slot < 0) begin
        res.status = ST_FULL;
      end else begin
        res.status = ST_INSERTED;
        pool_entry[slot] = rq;
        pool_used[slot] = 1'b1;
        if (len == 0) begin
          list_head[unit] = 6'(slot);
        end else begin
          cur = list_head[unit];
          pos = 0;
          if (rq.track > pool_entry[cur].track) begin
            // forward while the next track is below the new one and ascending
            while (pos + 1 < len) begin
              nxt = pool_next[cur];
              if (!(pool_entry[nxt].track < rq.track &&
                    pool_entry[nxt].track > pool_entry[cur].track)) break;
              cur = nxt;
              pos++;
            end
          end else begin
            // end of the ascending run, then past tracks not above the new one
            while (pos + 1 < len) begin
              nxt = pool_next[cur];
              if (pool_entry[cur].track > pool_entry[nxt].track) break;
              cur = nxt;
              pos++;
            end
            while (pos + 1 < len) begin
              nxt = pool_next[cur];
              if (pool_entry[nxt].track > rq.track) break;
              cur = nxt;
              pos++;
            end
          end
          pool_next[slot] = (pos + 1 < len) ? pool_next[cur] : 6'd0;
          pool_next[cur] = 6'(slot);
        end
        list_len[unit] = len + 1;
      end
    end else if (len == 0) begin
      res.status = ST_EMPTY;
    end else begin
      // hand out the head request and free its entry
      cur = list_head[unit];
      res.status = ST_POPPED;
      res.track = pool_entry[cur].track;
      res.sector = pool_entry[cur].sector;
      res.count = pool_entry[cur].count;
      res.is_write = pool_entry[cur].is_write;
      res.requester = pool_entry[cur].requester;
      pool_used[cur] = 1'b0;
      list_len[unit] = len - 1;
      list_head[unit] = (len > 1) ? pool_next[cur] : 6'd0;
    end
    return res;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < MaxPrinted) begin
      $display("%0t mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  // called at a falling edge; returns at the falling edge after the accept
  task automatic send_word(logic op, logic unit, req_t rq, logic typed, result_t want);
    result_t res;
    start = 1'b1;
    op_i = op;
    disk_unit_i = unit;
    req_track_i = rq.track;
    req_sector_i = rq.sector;
    sector_count_i = rq.count;
    is_write_i = rq.is_write;
    requester_i = rq.requester;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    res = queue_outcome(op, unit, rq);
    awaited_words.push_back(typed ? want : res);
    @(negedge clk_i);
  endtask

  task automatic idle_gap(int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // wait until every word has answered and the block is idle
  task automatic settle_idle();
    start = 1'b0;
    while (awaited_words.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_track_count(logic idx, logic [10:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    unit_tracks[idx] = val;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (awaited_words.size() == 0) begin
        flag_mismatch("unexpected result word, status", 32'(status_o), 32'd0);
      end else begin
        seen_want = awaited_words.pop_front();
        if (status_o !== seen_want.status)
          flag_mismatch("status", 32'(status_o), 32'(seen_want.status));
        if (out_track_o !== seen_want.track)
          flag_mismatch("out_track", 32'(out_track_o), 32'(seen_want.track));
        if (out_sector_o !== seen_want.sector)
          flag_mismatch("out_sector", 32'(out_sector_o), 32'(seen_want.sector));
        if (out_count_o !== seen_want.count)
          flag_mismatch("out_count", 32'(out_count_o), 32'(seen_want.count));
        if (out_is_write_o !== seen_want.is_write)
          flag_mismatch("out_is_write", 32'(out_is_write_o), 32'(seen_want.is_write));
        if (out_requester_o !== seen_want.requester)
          flag_mismatch("out_requester", 32'(out_requester_o),
                        32'(seen_want.requester));
      end
    end
  end

  // watchdog on cycles with neither an accepted word nor a result
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    plan_row_t  row;
    req_t       rq;
    logic       op;
    logic       unit;
    logic [10:0] t0;
    logic [10:0] t1;
    int         ins_pct;
    int         limit;
    int         trk;
    int         pick;

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (DirectedPlan[r]) begin
      row = DirectedPlan[r];
      if (row.kind == ROW_CFG) begin
        settle_idle();
        write_track_count(row.unit, row.cfg_val);
      end else begin
        send_word(row.op, row.unit, row.rq, row.typed, row.want);
        if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 9));
      end
    end

    // random phases alternating fill, drain and mixed traffic
    for (int phase = 0; phase < PhaseCount; phase++) begin
      settle_idle();
      case (phase)
        0: begin t0 = 11'd1024; t1 = 11'd1024; end
        1: begin t0 = 11'd2047; t1 = 11'd1; end
        2: begin t0 = 11'd1024; t1 = 11'd0; end
        3: begin t0 = 11'd0; t1 = 11'd2047; end
        4, 5, 6, 7: begin
          t0 = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 2047))
                                            : 11'($urandom_range(1, 1024));
          t1 = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 2047))
                                            : 11'($urandom_range(1, 1024));
        end
        default: begin t0 = TRACKS_RESET; t1 = TRACKS_RESET; end
      endcase
      write_track_count(CFG_TRACKS_UNIT0, t0);
      write_track_count(CFG_TRACKS_UNIT1, t1);
      case (phase % 3)
        0: ins_pct = 80;
        1: ins_pct = 25;
        default: ins_pct = 55;
      endcase

      for (int n = 0; n < PhaseWords; n++) begin
        // one unit carries most of a phase so its list grows long
        unit = ($urandom_range(0, 9) < 7) ? phase[0] : !phase[0];
        op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_POP;
        limit = int'(unit_tracks[unit]);
        pick = $urandom_range(0, 9);
        if (pick < 4) trk = $urandom_range(0, 1023);
        else if (pick < 7) trk = $urandom_range(0, 7);
        else if (pick < 9) trk = (limit == 0) ? 0 : limit - $urandom_range(0, 1);
        else trk = 1023;
        if (trk > 1023) trk = 1023;
        rq.track = 10'(trk);
        rq.sector = 4'($urandom_range(0, 15));
        rq.count = 8'($urandom_range(0, 255));
        rq.is_write = 1'($urandom_range(0, 1));
        rq.requester = 6'($urandom_range(0, 63));
        send_word(op, unit, rq, 1'b0, NoRes);
        if (phase < PhaseCount - QuietPhases && $urandom_range(0, 3) == 0) begin
          idle_gap($urandom_range(1, 9));
        end
      end
    end

    // drain and let any stray word show up
    settle_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (awaited_words.size() != 0) begin
      flag_mismatch("words never answered", awaited_words.size(), 0);
    end
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
